@@ rtl/core/psfc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the PI state-feedback controller.
`timescale 1ns / 1ps
`default_nettype none
package psfc_pkg;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned REG_IDX_W  = 3;

   localparam int unsigned P_SHIFT          = 7;
   localparam int unsigned FB_SHIFT         = 8;
   localparam int unsigned OUT_SHIFT        = 22;
   localparam int unsigned ANGLE_DIFF_SHIFT = 3;

   localparam logic signed [15:0] ANGLE_RATE_COEFF_RESET    = -16'sd19348;
   localparam logic signed [15:0] ANGLE_COEFF_RESET         = -16'sd25061;
   localparam logic signed [15:0] POSITION_RATE_COEFF_RESET = 16'sd17564;
   localparam logic signed [15:0] POSITION_COEFF_RESET      = 16'sd363;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_INTEGRAL_GAIN       = 3'd0,
      REG_PROPORTIONAL_GAIN   = 3'd1,
      REG_ANGLE_RATE_COEFF    = 3'd2,
      REG_ANGLE_COEFF         = 3'd3,
      REG_POSITION_RATE_COEFF = 3'd4,
      REG_POSITION_COEFF      = 3'd5
   } psfc_reg_idx_type;

   typedef struct packed {
      logic signed [15:0] integral_gain;
      logic signed [15:0] proportional_gain;
      logic signed [15:0] angle_rate_coeff;
      logic signed [15:0] angle_coeff;
      logic signed [15:0] position_rate_coeff;
      logic signed [15:0] position_coeff;
   } psfc_gains_type;

   typedef struct packed {
      logic [31:0] integral_prod;
      logic [31:0] proportional_prod;
      logic [31:0] angle_rate_prod;
      logic [31:0] position_rate_prod;
      logic [31:0] angle_prod;
      logic [31:0] position_prod;
   } psfc_prod_type;

   // Low 32 bits of a signed 32 by 16 product, which is the wrapped 32-bit result.
   function automatic logic [31:0] mul_lo32(input logic signed [31:0] a,
                                            input logic signed [15:0] b);
      logic signed [47:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/psfc_req_if.sv @@
// Input channel carrying one controller sample per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface psfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_position;
   logic signed [15:0] pendulum_angle;
   logic signed [31:0] cart_position;

   modport source (output valid, output target_position, output pendulum_angle,
                   output cart_position, input ready);
   modport sink (input valid, input target_position, input pendulum_angle,
                 input cart_position, output ready);
endinterface
`default_nettype wire

@@ rtl/core/psfc_rsp_if.sv @@
// Result channel carrying one drive force per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface psfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_force;

   modport source (output valid, output drive_force, input ready);
   modport sink (input valid, input drive_force, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pi_state_feedback_controller.sv @@
// PI position controller with state feedback: one sample in, one drive force out.
// The block accepts one transaction per clock cycle unless the result channel stalls
// and returns one result per sample in order via the input, product, sum and output
// registers; a result is held until taken. The rate is set by the six parallel 32 by 16
// multipliers of the product stage, each taking one sample per cycle when not stalled.
// The user must write gains over the APB-style port only while no sample is in flight;
// this is not enforced. Reads return the 16-bit register sign-extended to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module pi_state_feedback_controller (
   input  logic                            clock,
   input  logic                            reset,
   psfc_req_if.sink                        req_chan,
   psfc_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import psfc_pkg::*;

   psfc_gains_type gains;
   psfc_prod_type  prod;
   logic           prod_valid;
   logic           prod_ready;

   psfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   psfc_product_stage u_product (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .gains      (gains),
      .prod_valid (prod_valid),
      .prod       (prod),
      .prod_ready (prod_ready)
   );

   psfc_sum_stage u_sum (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod       (prod),
      .prod_ready (prod_ready),
      .rsp        (rsp_chan)
   );

   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("Result valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite
       && csr_paddr[CSR_ADDR_W-1:2] == REG_PROPORTIONAL_GAIN)
      |=> gains.proportional_gain == $past(csr_pwdata[15:0]))
      else $error("Proportional gain write not taken.");

   assert property (@(posedge clock) disable iff (reset)
      csr_prdata[31:16] == {16{csr_prdata[15]}})
      else $error("Register read data not sign-extended.");

   assert property (@(posedge clock) disable iff (reset)
      (prod_valid && !prod_ready) |=> (prod_valid && $stable(prod)))
      else $error("Stalled product stage changed its contents.");

endmodule
`default_nettype wire

@@ rtl/core/psfc_csr.sv @@
// APB-style register file holding the controller gains.
`timescale 1ns / 1ps
`default_nettype none
module psfc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psfc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psfc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output psfc_pkg::psfc_gains_type        gains
);
   import psfc_pkg::*;

   psfc_gains_type   gains_ff;
   psfc_gains_type   gains_in;
   psfc_reg_idx_type reg_idx;
   logic             wr_en;
   logic [15:0]      rd_val;

   assign reg_idx    = psfc_reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign gains      = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_INTEGRAL_GAIN:       gains_in.integral_gain       = csr_pwdata[15:0];
            REG_PROPORTIONAL_GAIN:   gains_in.proportional_gain   = csr_pwdata[15:0];
            REG_ANGLE_RATE_COEFF:    gains_in.angle_rate_coeff    = csr_pwdata[15:0];
            REG_ANGLE_COEFF:         gains_in.angle_coeff         = csr_pwdata[15:0];
            REG_POSITION_RATE_COEFF: gains_in.position_rate_coeff = csr_pwdata[15:0];
            REG_POSITION_COEFF:      gains_in.position_coeff      = csr_pwdata[15:0];
            default:                 gains_in = gains_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INTEGRAL_GAIN:       rd_val = gains_ff.integral_gain;
         REG_PROPORTIONAL_GAIN:   rd_val = gains_ff.proportional_gain;
         REG_ANGLE_RATE_COEFF:    rd_val = gains_ff.angle_rate_coeff;
         REG_ANGLE_COEFF:         rd_val = gains_ff.angle_coeff;
         REG_POSITION_RATE_COEFF: rd_val = gains_ff.position_rate_coeff;
         REG_POSITION_COEFF:      rd_val = gains_ff.position_coeff;
         default:                 rd_val = 16'd0;
      endcase
   end

   assign csr_prdata = sext16(rd_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.integral_gain       <= 16'sd0;
         gains_ff.proportional_gain   <= 16'sd0;
         gains_ff.angle_rate_coeff    <= ANGLE_RATE_COEFF_RESET;
         gains_ff.angle_coeff         <= ANGLE_COEFF_RESET;
         gains_ff.position_rate_coeff <= POSITION_RATE_COEFF_RESET;
         gains_ff.position_coeff      <= POSITION_COEFF_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/psfc_product_stage.sv @@
// Input register and the six gain products, with the stored previous angle and position.
`timescale 1ns / 1ps
`default_nettype none
module psfc_product_stage (
   input  logic                     clock,
   input  logic                     reset,
   psfc_req_if.sink                 req,
   input  psfc_pkg::psfc_gains_type gains,
   output logic                     prod_valid,
   output psfc_pkg::psfc_prod_type  prod,
   input  logic                     prod_ready
);
   import psfc_pkg::*;

   logic          in_valid_ff;
   logic [31:0]   in_target_ff;
   logic [15:0]   in_angle_ff;
   logic [31:0]   in_cart_ff;
   logic          prod_valid_ff;
   psfc_prod_type prod_ff;
   psfc_prod_type prod_in;
   logic [15:0]   last_angle_ff;
   logic [31:0]   last_position_ff;
   logic          prod_advance;
   logic          in_advance;
   logic [31:0]   err;
   logic [31:0]   angle_ext;
   logic [31:0]   angle_diff;
   logic [31:0]   position_diff;

   assign prod_advance = !prod_valid_ff || prod_ready;
   assign in_advance   = !in_valid_ff || prod_advance;
   assign req.ready    = in_advance;
   assign prod_valid   = prod_valid_ff;
   assign prod         = prod_ff;

   always_comb begin
      err           = in_target_ff - in_cart_ff;
      angle_ext     = sext16(in_angle_ff);
      angle_diff    = (angle_ext - sext16(last_angle_ff)) << ANGLE_DIFF_SHIFT;
      position_diff = in_cart_ff - last_position_ff;
      prod_in.integral_prod      = mul_lo32(err, gains.integral_gain);
      prod_in.proportional_prod  = mul_lo32(err, gains.proportional_gain);
      prod_in.angle_rate_prod    = mul_lo32(angle_diff, gains.angle_rate_coeff);
      prod_in.position_rate_prod = mul_lo32(position_diff, gains.position_rate_coeff);
      prod_in.angle_prod         = mul_lo32(angle_ext, gains.angle_coeff);
      prod_in.position_prod      = mul_lo32(in_cart_ff, gains.position_coeff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         prod_valid_ff    <= 1'b0;
         last_angle_ff    <= 16'd0;
         last_position_ff <= 32'd0;
      end else begin
         if (in_advance) begin
            in_valid_ff <= req.valid;
         end
         if (prod_advance) begin
            prod_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               last_angle_ff    <= in_angle_ff;
               last_position_ff <= in_cart_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && req.valid) begin
         in_target_ff <= req.target_position;
         in_angle_ff  <= req.pendulum_angle;
         in_cart_ff   <= req.cart_position;
      end
      if (prod_advance && in_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/psfc_sum_stage.sv @@
// Integrator, feedback and proportional sums, and the output register.
`timescale 1ns / 1ps
`default_nettype none
module psfc_sum_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    prod_valid,
   input  psfc_pkg::psfc_prod_type prod,
   output logic                    prod_ready,
   psfc_rsp_if.source              rsp
);
   import psfc_pkg::*;

   logic [31:0] integrator_acc_ff;
   logic [31:0] integrator_in;
   logic        sum_valid_ff;
   logic [31:0] sum_int_ff;
   logic [31:0] sum_pterm_ff;
   logic [31:0] sum_fb_ff;
   logic [31:0] fb_in;
   logic [31:0] total;
   logic        out_valid_ff;
   logic [15:0] out_force_ff;
   logic        out_advance;
   logic        sum_advance;

   assign out_advance = !out_valid_ff || rsp.ready;
   assign sum_advance = !sum_valid_ff || out_advance;
   assign prod_ready  = sum_advance;
   assign rsp.valid       = out_valid_ff;
   assign rsp.drive_force = out_force_ff;

   assign integrator_in = integrator_acc_ff + prod.integral_prod;
   assign fb_in = (prod.angle_rate_prod + prod.position_rate_prod
                   + prod.angle_prod + prod.position_prod) << FB_SHIFT;
   assign total = sum_pterm_ff + sum_int_ff - sum_fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_acc_ff <= 32'd0;
         sum_valid_ff      <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (sum_advance) begin
            sum_valid_ff <= prod_valid;
            if (prod_valid) begin
               integrator_acc_ff <= integrator_in;
            end
         end
         if (out_advance) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_advance && prod_valid) begin
         sum_int_ff   <= integrator_in;
         sum_pterm_ff <= prod.proportional_prod << P_SHIFT;
         sum_fb_ff    <= fb_in;
      end
      if (out_advance && sum_valid_ff) begin
         out_force_ff <= 16'({{(OUT_SHIFT - 16){total[31]}}, total[31:OUT_SHIFT]});
      end
   end

endmodule
`default_nettype wire
